>>> rtl/bbst_pkg.sv
package bbst_pkg;

  // request codes
  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_MAP    = 2'd1,
    ACT_BUILD  = 2'd2,
    ACT_XLATE  = 2'd3
  } bbst_action_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_MAP   = 3'd1,
    ST_BAD_COPY = 3'd2,
    ST_RANGE    = 3'd3,
    ST_REJECT   = 3'd4
  } bbst_status_e;

  typedef struct packed {
    bbst_action_e action;
    logic [7:0]   data_byte;
    logic         last_byte;
    logic [1:0]   copy_select;
    logic [8:0]   page_offset;
  } bbst_req_t;

  typedef struct packed {
    bbst_status_e status;
    logic [8:0]   nand_page;
    logic [2:0]   valid_count;
    logic [1:0]   chosen_copy;
  } bbst_rsp_t;

  localparam logic [63:0] MAP_SIG   = 64'h26f2_9a40_1ee6_84cf;
  localparam logic [7:0]  GOOD_MARK = 8'h00;
  localparam int          BLK_W     = 6;   // block numbers 0..63
  localparam int          BLK_N     = 64;
  localparam int          HDR_BYTES = 12;  // signature and generation
  localparam int          GEN_FIRST = 8;

  // signature byte j, most significant first
  function automatic logic [7:0] sig_byte(input logic [2:0] j);
    return MAP_SIG[{~j, 3'b000} +: 8];
  endfunction

endpackage

>>> rtl/boot_blockmap_select_translate_unit.sv
// Boot-region block map selector and page translator.
// Start and non-final map-byte requests finish in the accepting cycle, no result.
// Final map byte: S_EVAL reads one page-buffer word per cycle, then S_DECIDE gives the result.
// Build: one block per cycle in S_BUILD with a map and valid copy, else none; translate: S_XL1 to S_XL3.
// busy falls with the result strobe; results are never stalled.
// Reset (rst_ni low, asynchronous) clears control state; page buffer content undefined.
module boot_blockmap_select_translate_unit #(
  parameter int PAGES_PER_BLOCK = 64,
  parameter int FIRST_BLOCK     = 1,
  parameter int LAST_BLOCK      = 7,
  parameter int MAP_BYTES       = 76
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bbst_pkg::bbst_req_t req_i,
  output logic                done_o,
  output bbst_pkg::bbst_rsp_t rsp_o
);

  localparam int AW     = $clog2(MAP_BYTES);
  localparam int CW     = AW + 1;
  localparam int NBLK   = (LAST_BLOCK >= FIRST_BLOCK) ? (LAST_BLOCK - FIRST_BLOCK + 1) : 0;
  localparam int LDEPTH = (NBLK > 1) ? NBLK : 2;
  localparam int LW     = $clog2(LDEPTH);
  localparam int BW     = bbst_pkg::BLK_W;
  localparam int LENW   = BW + 1;
  // offset / PAGES_PER_BLOCK by reciprocal; exact for 9-bit offsets and divisors up to 1024
  localparam int RSH    = 20;
  localparam int RECIP  = (2**RSH + PAGES_PER_BLOCK - 1) / PAGES_PER_BLOCK;
  localparam int PW     = 30;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b000_0001,
    S_EVAL   = 7'b000_0010,
    S_DECIDE = 7'b000_0100,
    S_BUILD  = 7'b000_1000,
    S_XL1    = 7'b001_0000,
    S_XL2    = 7'b010_0000,
    S_XL3    = 7'b100_0000
  } state_e;

  state_e              state_q;
  logic                accept;

  // candidate write pointer: copy lane and byte within copy; lane 3 means page full
  logic [1:0]          wr_cp_q;
  logic [AW-1:0]       wr_ix_q;

  // evaluation sweep
  logic [CW-1:0]       cnt_q;
  logic [CW-1:0]       ev_j;
  logic                sig0_q, sig1_q, eq01_q, eq02_q, eq12_q;
  logic [31:0]         gen0_q, gen1_q;
  logic [bbst_pkg::BLK_N-1:0] good0_q, good1_q;
  logic [7:0]          b0, b1, b2;
  logic                pick0, pick1;
  logic [31:0]         pick_gen;

  // kept map
  logic [31:0]         kept_gen_q;
  logic                map_found_q;
  logic [bbst_pkg::BLK_N-1:0] good_q;

  // list build
  logic [LENW-1:0]     len_q;
  logic                desc_q;
  logic [BW-1:0]       bcnt_q;
  logic [BW-1:0]       blk_cur;
  logic                blk_ok;

  // translate
  logic [8:0]          off_q, q_q, sub_q;
  logic                hit_q;
  logic [PW-1:0]       recip_prod;
  logic [19:0]         back_prod;
  logic [16:0]         page_prod;
  logic                xl_hit;

  logic                done_q;
  bbst_pkg::bbst_rsp_t rsp_q;

  logic [23:0]         pb_rdata;
  logic                pb_we, pb_re;
  logic [BW-1:0]       lr_rdata;
  logic                lr_we, lr_re;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  assign pb_we = accept && (req_i.action == bbst_pkg::ACT_MAP) && (wr_cp_q != 2'd3);
  assign pb_re = (state_q == S_EVAL) && (cnt_q < CW'(MAP_BYTES));

  bbst_page_buf #(
    .MAP_BYTES(MAP_BYTES),
    .AW       (AW)
  ) u_page_buf (
    .clk_i  (clk_i),
    .we_i   (pb_we),
    .lane_i (wr_cp_q),
    .waddr_i(wr_ix_q),
    .wdata_i(req_i.data_byte),
    .re_i   (pb_re),
    .raddr_i(cnt_q[AW-1:0]),
    .rdata_o(pb_rdata)
  );

  assign blk_cur = desc_q ? (BW'(LAST_BLOCK) - bcnt_q) : (BW'(FIRST_BLOCK) + bcnt_q);
  assign blk_ok  = good_q[blk_cur];
  assign lr_we   = (state_q == S_BUILD) && blk_ok;
  assign xl_hit  = (q_q < 9'(len_q));
  assign lr_re   = (state_q == S_XL2) && xl_hit;

  bbst_list_ram #(
    .DEPTH(LDEPTH),
    .LW   (LW)
  ) u_list_ram (
    .clk_i  (clk_i),
    .we_i   (lr_we),
    .waddr_i(len_q[LW-1:0]),
    .wdata_i(blk_cur),
    .re_i   (lr_re),
    .raddr_i(q_q[LW-1:0]),
    .rdata_o(lr_rdata)
  );

  // ---------------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------------
  assign ev_j = cnt_q - CW'(1);
  assign b0   = pb_rdata[7:0];
  assign b1   = pb_rdata[15:8];
  assign b2   = pb_rdata[23:16];

  // first signed copy that matches another; copy 2 can never win on its own
  assign pick0    = sig0_q && (eq01_q || eq02_q);
  assign pick1    = sig1_q && eq12_q;
  assign pick_gen = pick0 ? gen0_q : gen1_q;

  assign recip_prod = PW'(off_q) * PW'(RECIP);
  assign back_prod  = 20'(q_q) * 20'(PAGES_PER_BLOCK);
  assign page_prod  = 17'(lr_rdata) * 17'(PAGES_PER_BLOCK);

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_cp_q     <= 2'd0;
      wr_ix_q     <= '0;
      cnt_q       <= '0;
      bcnt_q      <= '0;
      kept_gen_q  <= '0;
      map_found_q <= 1'b0;
      good_q      <= '0;
      len_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (req_i.action)
              bbst_pkg::ACT_START: begin
                map_found_q <= 1'b0;
                kept_gen_q  <= '0;
                good_q      <= '0;
                len_q       <= '0;
                wr_cp_q     <= 2'd0;
                wr_ix_q     <= '0;
              end
              bbst_pkg::ACT_MAP: begin
                if (req_i.last_byte) begin
                  wr_cp_q <= 2'd0;
                  wr_ix_q <= '0;
                  cnt_q   <= '0;
                  state_q <= S_EVAL;
                end else if (wr_cp_q != 2'd3) begin
                  if (wr_ix_q == AW'(MAP_BYTES - 1)) begin
                    wr_ix_q <= '0;
                    wr_cp_q <= wr_cp_q + 2'd1;
                  end else begin
                    wr_ix_q <= wr_ix_q + AW'(1);
                  end
                end
              end
              bbst_pkg::ACT_BUILD: begin
                len_q  <= '0;
                bcnt_q <= '0;
                if (!map_found_q || req_i.copy_select > 2'd1 || NBLK == 0) begin
                  done_q <= 1'b1;
                end else begin
                  state_q <= S_BUILD;
                end
              end
              bbst_pkg::ACT_XLATE: begin
                state_q <= S_XL1;
              end
              default: ;
            endcase
          end
        end
        S_EVAL: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(MAP_BYTES)) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if ((pick0 || pick1) && pick_gen >= kept_gen_q) begin
            kept_gen_q  <= pick_gen;
            map_found_q <= 1'b1;
            good_q      <= pick0 ? good0_q : good1_q;
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_BUILD: begin
          if (blk_ok) begin
            len_q <= len_q + LENW'(1);
          end
          bcnt_q <= bcnt_q + BW'(1);
          if (bcnt_q == BW'(NBLK - 1)) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_XL1: begin
          state_q <= S_XL2;
        end
        S_XL2: begin
          state_q <= S_XL3;
        end
        S_XL3: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // payload: sweep accumulators, translate pipeline, result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        desc_q <= (req_i.copy_select == 2'd1);
        off_q  <= req_i.page_offset;
        // pristine flags for a new sweep
        sig0_q  <= 1'b1;
        sig1_q  <= 1'b1;
        eq01_q  <= 1'b1;
        eq02_q  <= 1'b1;
        eq12_q  <= 1'b1;
        good0_q <= '0;
        good1_q <= '0;
        if (accept) begin
          rsp_q.nand_page   <= '0;
          rsp_q.chosen_copy <= 2'd0;
          rsp_q.valid_count <= 3'd0;
          if (!map_found_q) begin
            rsp_q.status <= bbst_pkg::ST_NO_MAP;
          end else if (req_i.copy_select > 2'd1) begin
            rsp_q.status <= bbst_pkg::ST_BAD_COPY;
          end else begin
            rsp_q.status <= bbst_pkg::ST_OK;
          end
        end
      end
      S_EVAL: begin
        // read data of word ev_j arrives in the cycle after its address
        if (cnt_q != '0) begin
          if (ev_j < CW'(bbst_pkg::GEN_FIRST)) begin
            sig0_q <= sig0_q && (b0 == bbst_pkg::sig_byte(ev_j[2:0]));
            sig1_q <= sig1_q && (b1 == bbst_pkg::sig_byte(ev_j[2:0]));
          end else if (ev_j < CW'(bbst_pkg::HDR_BYTES)) begin
            gen0_q <= {gen0_q[23:0], b0};
            gen1_q <= {gen1_q[23:0], b1};
          end else if (ev_j < CW'(bbst_pkg::HDR_BYTES + bbst_pkg::BLK_N)) begin
            good0_q[BW'(ev_j - CW'(bbst_pkg::HDR_BYTES))] <= (b0 == bbst_pkg::GOOD_MARK);
            good1_q[BW'(ev_j - CW'(bbst_pkg::HDR_BYTES))] <= (b1 == bbst_pkg::GOOD_MARK);
          end
          eq01_q <= eq01_q && (b0 == b1);
          eq02_q <= eq02_q && (b0 == b2);
          eq12_q <= eq12_q && (b1 == b2);
        end
      end
      S_DECIDE: begin
        rsp_q.nand_page   <= '0;
        rsp_q.valid_count <= len_q[2:0];
        rsp_q.chosen_copy <= (pick0 || !pick1) ? 2'd0 : 2'd1;
        if ((pick0 || pick1) && pick_gen >= kept_gen_q) begin
          rsp_q.status <= bbst_pkg::ST_OK;
        end else begin
          rsp_q.status <= bbst_pkg::ST_REJECT;
        end
      end
      S_BUILD: begin
        rsp_q.status      <= bbst_pkg::ST_OK;
        rsp_q.nand_page   <= '0;
        rsp_q.chosen_copy <= 2'd0;
        rsp_q.valid_count <= blk_ok ? (len_q[2:0] + 3'd1) : len_q[2:0];
      end
      S_XL1: begin
        q_q <= recip_prod[RSH +: 9];
      end
      S_XL2: begin
        sub_q <= off_q - back_prod[8:0];
        hit_q <= xl_hit;
      end
      S_XL3: begin
        rsp_q.valid_count <= len_q[2:0];
        rsp_q.chosen_copy <= 2'd0;
        if (hit_q) begin
          rsp_q.status    <= bbst_pkg::ST_OK;
          rsp_q.nand_page <= page_prod[8:0] + sub_q;
        end else begin
          rsp_q.status    <= bbst_pkg::ST_RANGE;
          rsp_q.nand_page <= '0;
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> rtl/bbst_page_buf.sv
// candidate page store: word j holds byte j of all three map copies
module bbst_page_buf #(
  parameter int MAP_BYTES = 76,
  parameter int AW        = $clog2(MAP_BYTES)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [1:0]    lane_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [23:0]   rdata_o
);

  logic [23:0] mem_q [MAP_BYTES];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      case (lane_i)
        2'd0:    mem_q[waddr_i][7:0]   <= wdata_i;
        2'd1:    mem_q[waddr_i][15:8]  <= wdata_i;
        2'd2:    mem_q[waddr_i][23:16] <= wdata_i;
        default: ;
      endcase
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bbst_list_ram.sv
// ordered good-block list
module bbst_list_ram #(
  parameter int DEPTH = 7,
  parameter int LW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [LW-1:0]              waddr_i,
  input  logic [bbst_pkg::BLK_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [LW-1:0]              raddr_i,
  output logic [bbst_pkg::BLK_W-1:0] rdata_o
);

  logic [bbst_pkg::BLK_W-1:0] mem_q [DEPTH];
  logic [bbst_pkg::BLK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
